@@ hw/rtl/imu_tilt_and_yaw_tracker_defines.svh @@
// Assertion macros for the IMU tilt and yaw tracker.
`ifndef IMU_TILT_AND_YAW_TRACKER_DEFINES_SVH
`define IMU_TILT_AND_YAW_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define ITYT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ITYT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
  else $error(msg);
`else
`define ITYT_ASSERT(lbl, prop, msg)
`define ITYT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/ityt_pkg.sv @@
// Shared types, constants and the arctangent table of the tilt and yaw tracker.
`default_nettype none
package ityt_pkg;

  localparam int ACC_W = 20;
  localparam int SUM_W = 24;
  localparam int CW    = 27;

  localparam logic [ACC_W-1:0] FULL_TURN = 20'd737280;
  localparam logic [15:0] W_ONE   = 16'd32768;
  localparam logic [15:0] W_RESET = 16'd32113;
  localparam logic signed [CW-1:0] DEG180_Z = 27'sd11796480;
  localparam logic signed [CW-1:0] HALF_TURN_OUT    = 27'sd23040;
  localparam logic signed [CW-1:0] QUARTER_TURN_OUT = 27'sd11520;

  localparam logic REG_GYRO_WEIGHT = 1'b0;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [SUM_W-1:0]   run_sum;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                 busy;
    logic signed [CW-1:0] angle;
  } cordic_stat_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ityt_front.sv @@
// Front end: accepts samples, integrates yaw and keeps the history running sum.
`default_nettype none
module ityt_front #(
  parameter int HISTORY_DEPTH = 5
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ityt_pkg::in_item_t   in_data_i,
  input  wire  [15:0]          gyro_weight_i,
  output logic                 push_o,
  output ityt_pkg::q_entry_t   push_data_o,
  input  ityt_pkg::q_stat_t    q_stat_i
);

  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_SUM  = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;

  logic [ityt_pkg::ACC_W-1:0] acc_q, acc_d;
  logic [ityt_pkg::ACC_W-1:0] weighted_q;
  logic [ityt_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [ityt_pkg::ACC_W-1:0] hist_q [HISTORY_DEPTH];
  logic [SLOT_W-1:0]          slot_q, slot_d;
  ityt_pkg::in_item_t         sample_q;

  logic signed [21:0] gz_ext, acc_sum, acc_wrap;
  logic [15:0]        w_sat;
  logic [35:0]        prod;
  logic               in_acc, do_push;

  assign in_ready_o = (state_q == F_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign do_push    = (state_q == F_SUM) && !q_stat_i.full;

  always_comb begin
    gz_ext  = 22'(in_data_i.gyro_z);
    acc_sum = $signed({2'b00, acc_q}) + gz_ext * 22'sd5;
    if (acc_sum < 22'sd0) begin
      acc_wrap = acc_sum + $signed({2'b00, ityt_pkg::FULL_TURN});
    end else if (acc_sum >= $signed({2'b00, ityt_pkg::FULL_TURN})) begin
      acc_wrap = acc_sum - $signed({2'b00, ityt_pkg::FULL_TURN});
    end else begin
      acc_wrap = acc_sum;
    end
    acc_d = acc_wrap[ityt_pkg::ACC_W-1:0];
  end

  always_comb begin
    w_sat = (gyro_weight_i > ityt_pkg::W_ONE) ? ityt_pkg::W_ONE : gyro_weight_i;
    prod  = 36'(acc_q) * 36'(w_sat);
  end

  always_comb begin
    sum_d  = sum_q - ityt_pkg::SUM_W'(hist_q[slot_q]) + ityt_pkg::SUM_W'(weighted_q);
    slot_d = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (in_acc) state_d = F_MUL;
      F_MUL:   state_d = F_SUM;
      F_SUM:   if (do_push) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      acc_q   <= '0;
      sum_q   <= '0;
      slot_q  <= '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) hist_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) acc_q <= acc_d;
      if (do_push) begin
        sum_q          <= sum_d;
        hist_q[slot_q] <= weighted_q;
        slot_q         <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) sample_q <= in_data_i;
    if (state_q == F_MUL) weighted_q <= ityt_pkg::ACC_W'((prod + 36'd16384) >> 15);
  end

  assign push_o               = do_push;
  assign push_data_o.accel_x  = sample_q.accel_x;
  assign push_data_o.accel_y  = sample_q.accel_y;
  assign push_data_o.accel_z  = sample_q.accel_z;
  assign push_data_o.run_sum  = sum_d;

endmodule
`default_nettype wire

@@ hw/rtl/ityt_queue.sv @@
// Two-entry queue between the front end and the angle engine.
`default_nettype none
module ityt_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ityt_pkg::q_entry_t   push_data_i,
  input  wire                  pop_i,
  output ityt_pkg::q_entry_t   head_o,
  output ityt_pkg::q_stat_t    stat_o
);

  ityt_pkg::q_entry_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule
`default_nettype wire

@@ hw/rtl/ityt_cordic.sv @@
// Iterative CORDIC vectoring unit: atan2 in 1/128 degree, one rotation per cycle.
`default_nettype none
module ityt_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    start_i,
  input  wire  logic signed [ityt_pkg::CW-1:0]   y0_i,
  input  wire  logic signed [ityt_pkg::CW-1:0]   x0_i,
  output ityt_pkg::cordic_stat_t                 stat_o
);

  localparam int CW = ityt_pkg::CW;

  logic signed [CW-1:0] x_q, y_q, z_q;
  logic signed [CW-1:0] dx, dy, rnd;
  logic [4:0]           i_q;
  logic                 busy_q, zero_q;

  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign rnd = (z_q + 27'sd256) >>> 9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q    <= '0;
    end else if (busy_q) begin
      if (i_q == 5'(CORDIC_STEPS - 1)) busy_q <= 1'b0;
      i_q <= i_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      zero_q <= (x0_i == '0) && (y0_i == '0);
      // fold the left half plane onto the right and preload +-180
      if (x0_i < 0) begin
        x_q <= -x0_i;
        y_q <= -y0_i;
        z_q <= (y0_i >= 0) ? ityt_pkg::DEG180_Z : -ityt_pkg::DEG180_Z;
      end else begin
        x_q <= x0_i;
        y_q <= y0_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ityt_pkg::atan_entry(i_q);
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ityt_pkg::atan_entry(i_q);
      end
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.angle = zero_q ? '0 : rnd;

endmodule
`default_nettype wire

@@ hw/rtl/ityt_back.sv @@
// Angle engine: magnitude root, pitch and roll CORDIC, yaw average and result register.
`default_nettype none
module ityt_back #(
  parameter int HISTORY_DEPTH = 5,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  output logic                 pop_o,
  input  ityt_pkg::q_entry_t   head_i,
  input  ityt_pkg::q_stat_t    q_stat_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ityt_pkg::out_item_t  out_data_o
);

  localparam int CW       = ityt_pkg::CW;
  localparam int NUM_W    = ityt_pkg::SUM_W + 1;
  localparam int RECIP_SH = 26;
  localparam logic [26:0] RECIP =
    27'(((64'd1 << RECIP_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_MAG   = 5'b00010,
    B_ROOT  = 5'b00100,
    B_PITCH = 5'b01000,
    B_PUT   = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;

  logic signed [15:0]   ax_q, ay_q, az_q;
  logic [47:0]          rad_q, root_q, bit_q, trial;
  logic signed [31:0]   sq_y, sq_z;
  logic [31:0]          magsq;
  logic [NUM_W-5:0]     num_q;
  logic [47:0]          quo_prod;
  logic [16:0]          quo_q;
  logic                 out_valid_q, load_out;
  ityt_pkg::out_item_t  out_q;

  logic                  roll_start, pitch_start;
  logic signed [CW-1:0]  roll_y0, roll_x0, pitch_y0, pitch_x0;
  logic signed [CW-1:0]  pitch_c, roll_c;
  logic signed [17:0]    avg_s, yaw_s;
  ityt_pkg::cordic_stat_t roll_st, pitch_st;

  assign pop_o       = (state_q == B_IDLE) && !q_stat_i.empty;
  assign roll_start  = (state_q == B_MAG);
  assign pitch_start = (state_q == B_ROOT) && (bit_q == '0);
  assign load_out    = (state_q == B_PUT) && !roll_st.busy &&
                       (!out_valid_q || out_ready_i);

  assign roll_y0  = CW'(ay_q) <<< 8;
  assign roll_x0  = CW'(az_q) <<< 8;
  assign pitch_y0 = -(CW'(ax_q) <<< 8);
  assign pitch_x0 = CW'(root_q[23:0]);

  ityt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(roll_start),
    .y0_i   (roll_y0),
    .x0_i   (roll_x0),
    .stat_o (roll_st)
  );

  ityt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pitch_start),
    .y0_i   (pitch_y0),
    .x0_i   (pitch_x0),
    .stat_o (pitch_st)
  );

  always_comb begin
    sq_y     = ay_q * ay_q;
    sq_z     = az_q * az_q;
    magsq    = $unsigned(sq_y) + $unsigned(sq_z);
    trial    = root_q + bit_q;
    // divide by HISTORY_DEPTH through a scaled reciprocal
    quo_prod = 48'(num_q) * 48'(RECIP);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (pop_o) state_d = B_MAG;
      B_MAG:   state_d = B_ROOT;
      B_ROOT:  if (bit_q == '0) state_d = B_PITCH;
      B_PITCH: if (!pitch_st.busy) state_d = B_PUT;
      B_PUT:   if (load_out) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ax_q  <= head_i.accel_x;
      ay_q  <= head_i.accel_y;
      az_q  <= head_i.accel_z;
      num_q <= (NUM_W-4)'((NUM_W'(head_i.run_sum) + NUM_W'(HISTORY_DEPTH * 8)) >> 4);
    end

    if (state_q == B_MAG) quo_q <= 17'(quo_prod >> RECIP_SH);

    if (state_q == B_MAG) begin
      rad_q  <= {magsq, 16'd0};
      root_q <= '0;
      bit_q  <= 48'd1 << 46;
    end else if ((state_q == B_ROOT) && (bit_q != '0)) begin
      if (rad_q >= trial) begin
        rad_q  <= rad_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    if (load_out) out_q <= out_item_d();
  end

  always_comb begin
    pitch_c = pitch_st.angle;
    if (pitch_c > ityt_pkg::QUARTER_TURN_OUT) pitch_c = ityt_pkg::QUARTER_TURN_OUT;
    if (pitch_c < -ityt_pkg::QUARTER_TURN_OUT) pitch_c = -ityt_pkg::QUARTER_TURN_OUT;
    roll_c = roll_st.angle;
    if (roll_c > ityt_pkg::HALF_TURN_OUT) roll_c = ityt_pkg::HALF_TURN_OUT;
    if (roll_c < -ityt_pkg::HALF_TURN_OUT) roll_c = -ityt_pkg::HALF_TURN_OUT;
    avg_s = $signed({1'b0, quo_q});
    yaw_s = (avg_s > 18'sd23040) ? avg_s - 18'sd46080 : avg_s;
  end

  function automatic ityt_pkg::out_item_t out_item_d();
    ityt_pkg::out_item_t r;
    r.pitch_angle = pitch_c[14:0];
    r.roll_angle  = roll_c[15:0];
    r.yaw_angle   = yaw_s[15:0];
    return r;
  endfunction

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/imu_tilt_and_yaw_tracker.sv @@
// Top level of the IMU tilt and yaw tracker: register port, front end, queue, angle engine.
//
//   port      direction  transaction
//   in_*      sink       one raw sample: accel_x, accel_y, accel_z, gyro_z
//   out_*     source     one result: pitch_angle, roll_angle, yaw_angle
//   p*        APB slave  gyro_weight at address 0
//
// The front end takes a sample through its idle, multiply and sum states; the angle
// engine takes the next sample only once its result is loaded, and its time per
// sample is set by the 24-step magnitude root followed by the pitch CORDIC; roll and
// the yaw average run alongside the root. Reset clears yaw state and history at once.
// A full output register stalls the engine, a full queue stalls the front end.
`default_nettype none
`include "imu_tilt_and_yaw_tracker_defines.svh"
module imu_tilt_and_yaw_tracker #(
  parameter int HISTORY_DEPTH = 5,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  ityt_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ityt_pkg::out_item_t  out_data_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [15:0]        weight_q;
  logic               push, pop;
  ityt_pkg::q_entry_t push_data, head;
  ityt_pkg::q_stat_t  q_stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ityt_pkg::REG_GYRO_WEIGHT) ? {16'd0, weight_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= ityt_pkg::W_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == ityt_pkg::REG_GYRO_WEIGHT)) begin
      weight_q <= pwdata[15:0];
    end
  end

  ityt_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .gyro_weight_i(weight_q),
    .push_o       (push),
    .push_data_o  (push_data),
    .q_stat_i     (q_stat)
  );

  ityt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  ityt_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_o      (pop),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `ITYT_ASSERT(a_push_not_full, (push |-> !q_stat.full), "push into full queue")
  `ITYT_ASSERT(a_pop_not_empty, (pop |-> !q_stat.empty), "pop from empty queue")
  `ITYT_ASSERT_NEXT(a_push_fills, push && !pop && q_stat.empty, !q_stat.empty, "push lost")
  `ITYT_ASSERT(a_yaw_range, (out_valid_o |-> (out_data_o.yaw_angle >= -16'sd23040 && out_data_o.yaw_angle <= 16'sd23040)), "yaw out of range")

endmodule
`default_nettype wire

@@ tb/imu_tilt_and_yaw_tracker_tb.sv @@
// Self-checking testbench for the IMU tilt and yaw tracker: random samples, APB weight changes.
`default_nettype none
module imu_tilt_and_yaw_tracker_tb;

  localparam int DEPTH = 5;
  localparam int STEPS = 16;
  localparam int FULL = 737280;
  localparam int LIMIT_CYCLES = 400000;

  // Predicts tracker output and compares each outgoing transaction in order.
  class angle_scoreboard;
    int unsigned weight;
    int unsigned yaw_acc;
    int unsigned hist [DEPTH];
    int unsigned slot;
    int unsigned run_sum;
    ityt_pkg::out_item_t pending [$];
    int errors;
    int checked;

    function new();
      weight = 32113;
      yaw_acc = 0;
      foreach (hist[k]) hist[k] = 0;
      slot = 0;
      run_sum = 0;
      errors = 0;
      checked = 0;
    endfunction

    function longint atan_step(int idx);
      longint tab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};
      return tab[idx];
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint root64(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return longint'(r);
    endfunction

    function longint vector_angle(longint y, longint x, longint lim);
      longint z;
      longint dx;
      longint dy;
      longint r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 11796480 : -11796480;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += atan_step(i);
        end else begin
          x -= dx; y += dy; z -= atan_step(i);
        end
      end
      r = fshift(z + 256, 9);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function void note_sample(ityt_pkg::in_item_t s);
      longint ax, ay, az, gz, mag, acc, avg;
      int unsigned w, wy;
      ityt_pkg::out_item_t o;
      ax = s.accel_x; ay = s.accel_y; az = s.accel_z; gz = s.gyro_z;
      mag = root64(longint'(ay * ay + az * az) << 16);
      o.pitch_angle = 15'(vector_angle(-ax * 256, mag, 11520));
      o.roll_angle = 16'(vector_angle(ay * 256, az * 256, 23040));
      acc = longint'(yaw_acc) + gz * 5;
      if (acc < 0) acc += FULL;
      if (acc >= FULL) acc -= FULL;
      yaw_acc = int'(acc);
      w = (weight > 32768) ? 32768 : weight;
      wy = int'((longint'(yaw_acc) * w + 16384) >> 15);
      if (slot >= DEPTH) slot = 0;
      run_sum = run_sum - hist[slot] + wy;
      hist[slot] = wy;
      slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
      avg = (run_sum + DEPTH * 8) / (DEPTH * 16);
      if (avg > 23040) avg -= 46080;
      o.yaw_angle = 16'(avg);
      pending.push_back(o);
    endfunction

    function void check_result(ityt_pkg::out_item_t got);
      ityt_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("result with no expectation: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.pitch_angle !== e.pitch_angle) begin
        $error("pitch_angle expected %0d actual %0d", e.pitch_angle, got.pitch_angle);
        errors++;
      end
      if (got.roll_angle !== e.roll_angle) begin
        $error("roll_angle expected %0d actual %0d", e.roll_angle, got.roll_angle);
        errors++;
      end
      if (got.yaw_angle !== e.yaw_angle) begin
        $error("yaw_angle expected %0d actual %0d", e.yaw_angle, got.yaw_angle);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ityt_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ityt_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  angle_scoreboard board = new();
  int unsigned cycle_count = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  bit offering = 1'b0;
  int unsigned samples_sent = 0;

  always #10 clk_i = ~clk_i;

  imu_tilt_and_yaw_tracker dut (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
      out_ready_i <= !hold_off && (calm || $urandom_range(99) >= 28);
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.weight = data[15:0];
  endtask

  // Drop valid once after the last accepted transaction.
  task automatic drop_valid();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_sample(ityt_pkg::in_item_t s);
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        drop_valid();
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    offering = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_sample(s);
    samples_sent++;
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ityt_pkg::in_item_t rand_sample();
    ityt_pkg::in_item_t s;
    s.accel_x = pick_axis();
    s.accel_y = pick_axis();
    s.accel_z = pick_axis();
    s.gyro_z = pick_axis();
    return s;
  endfunction

  task automatic drain();
    drop_valid();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    ityt_pkg::in_item_t s;
    logic signed [15:0] edge_vals [6];
    edge_vals = '{16'sh8000, 16'sh7fff, 0, 1, -1, 16'sh4000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vector, axis extremes, gyro wrap both ways.
    send_sample('{0, 0, 0, 0});
    foreach (edge_vals[k]) begin
      send_sample('{edge_vals[k], edge_vals[(k + 1) % 6], edge_vals[(k + 2) % 6],
                    edge_vals[(k + 3) % 6]});
    end
    send_sample('{0, 0, -100, 16'sh8000});
    send_sample('{0, -5, -100, 16'sh7fff});
    send_sample('{100, 5, -100, 16'sh7fff});
    send_sample('{-100, 0, 0, 16'sh8000});
    send_sample('{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send_sample('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    drain();

    // Weight extremes, including a value above one that must saturate.
    foreach (edge_vals[k]) begin
      case (k % 6)
        0: apb_write(3'd0, 32'd32768);
        1: apb_write(3'd0, 32'd0);
        2: apb_write(3'd0, 32'hffff);
        3: apb_write(3'd0, 32'd40000);
        4: apb_write(3'd0, 32'd1);
        default: apb_write(3'd0, 32'd32113);
      endcase
      repeat (6) send_sample(rand_sample());
      drain();
    end

    // Fill the block while the receiver holds off.
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (12) send_sample(rand_sample());
        drop_valid();
      end
    join

    for (int n = 0; n < 760; n++) begin
      calm = (n >= 300 && n < 400);
      if (n % 190 == 189) begin
        drain();
        apb_write(3'd0, $urandom_range(40000));
      end
      s = rand_sample();
      send_sample(s);
    end
    calm = 1'b0;
    drain();

    $display("Covered %0d samples, %0d results checked, weights from 0 to above one.",
             samples_sent, board.checked);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
